[src/clnw_pkg.sv]
// shared types, codes and tables of the character display nibble writer
package clnw_pkg;

    // request codes
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_CHAR  = 2'd1;
    localparam logic [1:0] REQ_INIT  = 2'd2;

    // wait codes
    localparam logic [2:0] WAIT_NONE    = 3'd0;
    localparam logic [2:0] WAIT_40US    = 3'd1;
    localparam logic [2:0] WAIT_200US   = 3'd2;
    localparam logic [2:0] WAIT_5MS     = 3'd3;
    localparam logic [2:0] WAIT_CLEAR   = 3'd4;

    // expander control nibbles and masks
    localparam logic [3:0] CTRL_CMD  = 4'hC;
    localparam logic [3:0] CTRL_DATA = 4'hD;
    localparam logic [7:0] EN_CLEAR  = 8'hFB;

    // display commands and characters
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_LINE_TWO = 8'hC0;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    // defaults
    localparam int DEF_MESSAGE_LIMIT = 32;
    localparam int DEF_QUEUE_DEPTH   = 4;
    localparam logic [5:0] LINE_WIDTH_RESET = 6'd16;

    // sequence lengths, as last byte index
    localparam logic [4:0] LAST_IDX_INIT  = 5'd23;
    localparam logic [4:0] LAST_IDX_MOVE  = 5'd7;
    localparam logic [4:0] LAST_IDX_PLAIN = 5'd3;

    // one classified request for the sequencer
    typedef struct packed {
        logic       is_init;
        logic       has_move;
        logic [3:0] main_ctrl;
        logic [7:0] main_value;
        logic [2:0] main_wait;
    } job_t;

    typedef struct packed {
        logic [7:0] xbyte;
        logic [2:0] wcode;
    } init_entry_t;

    // expander byte for one step of a nibble transfer: high nibble first, enable then cleared
    function automatic logic [7:0] nibble_byte(input logic [3:0] ctrl, input logic [7:0] value,
                                               input logic [1:0] step);
        logic [3:0] nib;
        logic [7:0] b;
        nib = step[1] ? value[3:0] : value[7:4];
        b   = {nib, ctrl};
        if (step[0])
        begin
            b = b & EN_CLEAR;
        end
        return b;
    endfunction

    // power-up sequence
    function automatic init_entry_t init_entry(input logic [4:0] idx);
        init_entry_t e;
        unique case (idx)
            5'd0:    e = '{8'h3C, WAIT_NONE};
            5'd1:    e = '{8'h38, WAIT_5MS};
            5'd2:    e = '{8'h3C, WAIT_NONE};
            5'd3:    e = '{8'h38, WAIT_200US};
            5'd4:    e = '{8'h3C, WAIT_NONE};
            5'd5:    e = '{8'h38, WAIT_40US};
            5'd6:    e = '{8'h2C, WAIT_NONE};
            5'd7:    e = '{8'h28, WAIT_40US};
            5'd8:    e = '{8'h2C, WAIT_NONE};
            5'd9:    e = '{8'h28, WAIT_NONE};
            5'd10:   e = '{8'h8C, WAIT_NONE};
            5'd11:   e = '{8'h88, WAIT_40US};
            5'd12:   e = '{8'h0C, WAIT_NONE};
            5'd13:   e = '{8'h08, WAIT_NONE};
            5'd14:   e = '{8'hEC, WAIT_NONE};
            5'd15:   e = '{8'hE8, WAIT_40US};
            5'd16:   e = '{8'h0C, WAIT_NONE};
            5'd17:   e = '{8'h08, WAIT_NONE};
            5'd18:   e = '{8'h1C, WAIT_NONE};
            5'd19:   e = '{8'h18, WAIT_CLEAR};
            5'd20:   e = '{8'h0C, WAIT_NONE};
            5'd21:   e = '{8'h08, WAIT_NONE};
            5'd22:   e = '{8'h6C, WAIT_NONE};
            5'd23:   e = '{8'h68, WAIT_40US};
            default: e = '{8'h00, WAIT_NONE};
        endcase
        return e;
    endfunction

endpackage

[src/clnw_front.sv]
// front end: takes requests, tracks message position and line, classifies into jobs
module clnw_front
    import clnw_pkg::*;
#(
    parameter int MESSAGE_LIMIT = DEF_MESSAGE_LIMIT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [5:0] cfg_write_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [7:0] char_code,
    input  logic       q_full,
    output logic       q_push,
    output job_t       q_job
);

    localparam logic [5:0] LIMIT = 6'(MESSAGE_LIMIT);

    logic [5:0] line_width_reg;
    logic [5:0] char_count_reg, char_count_next;
    logic       second_reg, second_next;
    logic       accept;
    logic       move;
    logic       second_mid;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // classify the request and update message state
    always_comb
    begin
        char_count_next = char_count_reg;
        second_next     = second_reg;
        q_push          = 1'b0;
        q_job           = '{1'b0, 1'b0, CTRL_CMD, CMD_CLEAR, WAIT_CLEAR};
        move            = (char_count_reg == line_width_reg) && !second_reg;
        second_mid      = second_reg || move;
        if (accept)
        begin
            unique case (req_type)
                REQ_START:
                begin
                    char_count_next = '0;
                    second_next     = 1'b0;
                    q_push          = 1'b1;
                end
                REQ_CHAR:
                begin
                    if (char_count_reg < LIMIT)
                    begin
                        char_count_next = char_count_reg + 6'd1;
                        q_push          = 1'b1;
                        q_job.has_move  = move;
                        q_job.main_wait = WAIT_40US;
                        second_next     = 1'b1;
                        if (char_code == CHAR_NEWLINE && !second_mid)
                        begin
                            // newline that opens line two is swallowed
                            q_job.main_ctrl  = CTRL_CMD;
                            q_job.main_value = CMD_LINE_TWO;
                        end
                        else
                        begin
                            q_job.main_ctrl  = CTRL_DATA;
                            q_job.main_value = char_code;
                            second_next      = second_mid;
                        end
                    end
                end
                REQ_INIT:
                begin
                    q_push        = 1'b1;
                    q_job.is_init = 1'b1;
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    // state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
            char_count_reg <= '0;
            second_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                line_width_reg <= cfg_write_data;
            end
            char_count_reg <= char_count_next;
            second_reg     <= second_next;
        end
    end

endmodule

[src/clnw_queue.sv]
// small job queue between front end and sequencer
module clnw_queue
    import clnw_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == COUNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[src/clnw_sequencer.sv]
// back end: expands jobs into expander bytes, one per cycle unless the output stalls, into an output register
module clnw_sequencer
    import clnw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       q_job,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] expander_byte,
    output logic [2:0] wait_code,
    output logic       last
);

    job_t        job_reg, job_next;
    logic [4:0]  idx_reg, idx_next;
    logic        busy_reg, busy_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic [2:0]  wait_reg, wait_next;
    logic        last_reg, last_next;
    logic        advance;
    logic        emit;
    logic        at_end;
    logic        load;
    logic [4:0]  last_idx;
    logic [1:0]  step;
    init_entry_t ie;
    logic [7:0]  cur_byte;
    logic [2:0]  cur_wait;

    assign out_valid     = out_valid_reg;
    assign expander_byte = byte_reg;
    assign wait_code     = wait_reg;
    assign last          = last_reg;
    assign step          = idx_reg[1:0];

    // byte for the current index of the current job
    always_comb
    begin
        ie = init_entry(idx_reg);
        if (job_reg.is_init)
        begin
            last_idx = LAST_IDX_INIT;
            cur_byte = ie.xbyte;
            cur_wait = ie.wcode;
        end
        else if (job_reg.has_move && !idx_reg[2])
        begin
            last_idx = LAST_IDX_MOVE;
            cur_byte = nibble_byte(CTRL_CMD, CMD_LINE_TWO, step);
            cur_wait = (step == 2'd3) ? WAIT_40US : WAIT_NONE;
        end
        else
        begin
            last_idx = job_reg.has_move ? LAST_IDX_MOVE : LAST_IDX_PLAIN;
            cur_byte = nibble_byte(job_reg.main_ctrl, job_reg.main_value, step);
            cur_wait = (step == 2'd3) ? job_reg.main_wait : WAIT_NONE;
        end
        at_end = (idx_reg == last_idx);
    end

    // sequencing and output register
    always_comb
    begin
        advance        = !out_valid_reg || out_ready;
        emit           = busy_reg && advance;
        load           = (!busy_reg || (emit && at_end)) && !q_empty;
        q_pop          = load;
        busy_next      = busy_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        out_valid_next = advance ? busy_reg : out_valid_reg;
        byte_next      = byte_reg;
        wait_next      = wait_reg;
        last_next      = last_reg;
        if (emit)
        begin
            byte_next = cur_byte;
            wait_next = cur_wait;
            last_next = at_end;
            idx_next  = idx_reg + 5'd1;
            if (at_end)
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            job_next  = q_job;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        byte_reg <= byte_next;
        wait_reg <= wait_next;
        last_reg <= last_next;
    end

endmodule

[src/char_lcd_nibble_writer.sv]
// top level of the character display nibble writer
// Turns display requests into expander bytes for a character display run in 4-bit mode.
// A start request yields 4 bytes, a character 4 bytes (8 when it also opens line two),
// init 24 bytes, and a dropped character or unused code none. The sequencer puts out
// one byte per cycle while the output does not stall it; that byte-per-cycle sequencer
// sets the rate. The front end takes a request in any cycle the job queue (QUEUE_DEPTH
// entries) has room, even while results wait at the output; a taken request passes the
// job queue and the sequencer's job and output registers before its first byte shows.
// line_width may only be written while no request is in flight.
module char_lcd_nibble_writer
    import clnw_pkg::*;
#(
    parameter int MESSAGE_LIMIT = DEF_MESSAGE_LIMIT,
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [5:0] cfg_write_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] expander_byte,
    output logic [2:0] wait_code,
    output logic       last
);

    job_t push_job;
    job_t pop_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    // request classification
    clnw_front #(
        .MESSAGE_LIMIT(MESSAGE_LIMIT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .char_code     (char_code),
        .q_full        (full),
        .q_push        (push),
        .q_job         (push_job)
    );

    // job queue
    clnw_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .full    (full),
        .pop     (pop),
        .pop_job (pop_job),
        .empty   (empty)
    );

    // byte sequencer
    clnw_sequencer u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_job        (pop_job),
        .q_empty      (empty),
        .q_pop        (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .expander_byte(expander_byte),
        .wait_code    (wait_code),
        .last         (last)
    );

endmodule

[src/clnw_checker.sv]
// port-level checks of the nibble writer and their binding
module clnw_checker
    import clnw_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] expander_byte,
    input logic [2:0] wait_code,
    input logic       last
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(expander_byte) && $stable(wait_code)
            && $stable(last))
        else $error("stalled result changed");

    // the closing byte of a request always carries a wait
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> wait_code != WAIT_NONE)
        else $error("last byte without wait");

    // enable-high bytes never carry a wait
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && expander_byte[2] |-> wait_code == WAIT_NONE && !last)
        else $error("enable-high byte with wait or last");

    // an enable-high byte is followed at once by the same byte with enable cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && expander_byte[2] |=>
            out_valid && expander_byte == ($past(expander_byte) & EN_CLEAR))
        else $error("enable pulse not completed");

endmodule

bind char_lcd_nibble_writer clnw_checker u_clnw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .expander_byte(expander_byte),
    .wait_code    (wait_code),
    .last         (last)
);

[dv/testbench.sv]
// testbench for the character display nibble writer: request stimulus, byte prediction, checking
module testbench
    import clnw_pkg::*;
;

    localparam int          MSG_LIMIT     = DEF_MESSAGE_LIMIT;
    localparam logic [1:0]  REQ_UNUSED    = 2'd3;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          LONG_HOLD     = 300;
    localparam int          STALL_LIMIT   = 3000;

    // power-up sequence values
    localparam logic [7:0]  INIT_WAKE        = 8'h3C;
    localparam logic [7:0]  INIT_FOUR_BIT    = 8'h2C;
    localparam logic [7:0]  CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0]  CMD_DISPLAY_ON   = 8'h0E;
    localparam logic [7:0]  CMD_ENTRY_MODE   = 8'h06;

    typedef struct packed {
        logic [7:0] xbyte;
        logic [2:0] wcode;
        logic       last_flag;
    } expander_beat_t;

    // predicted display state and the expander bytes still owed
    class display_scoreboard;
        logic [5:0]     width_reg;
        logic [5:0]     taken;
        logic           line_two;
        expander_beat_t owed[$];
        int unsigned    mismatches;
        int unsigned    checked;
        int unsigned    productive;
        int unsigned    accepted;

        function new();
            width_reg  = LINE_WIDTH_RESET;
            taken      = '0;
            line_two   = 1'b0;
            mismatches = 0;
            checked    = 0;
            productive = 0;
            accepted   = 0;
        endfunction

        function void set_width(logic [5:0] w);
            width_reg = w;
        endfunction

        function void push_beat(logic [7:0] b, logic [2:0] w);
            expander_beat_t e;
            e.xbyte     = b;
            e.wcode     = w;
            e.last_flag = 1'b0;
            owed.push_back(e);
        endfunction

        // one display byte as two nibbles, each with enable set then cleared
        function void push_display_byte(logic [3:0] ctrl, logic [7:0] value, logic [2:0] w);
            logic [7:0] hi;
            logic [7:0] lo;
            hi = {value[7:4], ctrl};
            lo = {value[3:0], ctrl};
            push_beat(hi, WAIT_NONE);
            push_beat(hi & EN_CLEAR, WAIT_NONE);
            push_beat(lo, WAIT_NONE);
            push_beat(lo & EN_CLEAR, w);
        endfunction

        // work out the bytes that one accepted request causes
        function void note_request(logic [1:0] rq, logic [7:0] ch);
            int         first;
            logic [5:0] pos;
            first = owed.size();
            accepted++;
            case (rq)
                REQ_START:
                begin
                    taken    = '0;
                    line_two = 1'b0;
                    push_display_byte(CTRL_CMD, CMD_CLEAR, WAIT_CLEAR);
                end
                REQ_CHAR:
                begin
                    if (taken < MSG_LIMIT)
                    begin
                        pos   = taken;
                        taken = taken + 6'd1;
                        if (pos == width_reg && !line_two)
                        begin
                            push_display_byte(CTRL_CMD, CMD_LINE_TWO, WAIT_40US);
                            line_two = 1'b1;
                        end
                        if (ch == CHAR_NEWLINE && !line_two)
                        begin
                            push_display_byte(CTRL_CMD, CMD_LINE_TWO, WAIT_40US);
                            line_two = 1'b1;
                        end
                        else
                        begin
                            push_display_byte(CTRL_DATA, ch, WAIT_40US);
                        end
                    end
                end
                REQ_INIT:
                begin
                    push_beat(INIT_WAKE, WAIT_NONE);
                    push_beat(INIT_WAKE & EN_CLEAR, WAIT_5MS);
                    push_beat(INIT_WAKE, WAIT_NONE);
                    push_beat(INIT_WAKE & EN_CLEAR, WAIT_200US);
                    push_beat(INIT_WAKE, WAIT_NONE);
                    push_beat(INIT_WAKE & EN_CLEAR, WAIT_40US);
                    push_beat(INIT_FOUR_BIT, WAIT_NONE);
                    push_beat(INIT_FOUR_BIT & EN_CLEAR, WAIT_40US);
                    push_display_byte(CTRL_CMD, CMD_FUNCTION_SET, WAIT_40US);
                    push_display_byte(CTRL_CMD, CMD_DISPLAY_ON, WAIT_40US);
                    push_display_byte(CTRL_CMD, CMD_CLEAR, WAIT_CLEAR);
                    push_display_byte(CTRL_CMD, CMD_ENTRY_MODE, WAIT_40US);
                end
                default:
                begin
                end
            endcase
            if (owed.size() > first)
            begin
                owed[owed.size() - 1].last_flag = 1'b1;
                productive++;
            end
        endfunction

        // compare one output byte with the oldest owed one
        function void check_byte(logic [7:0] b, logic [2:0] w, logic l);
            expander_beat_t e;
            checked++;
            if (owed.size() == 0)
            begin
                $error("unexpected expander byte %h (wait %0d, last %0d)", b, w, l);
                mismatches++;
            end
            else
            begin
                e = owed.pop_front();
                if (b !== e.xbyte)
                begin
                    $error("expander_byte: expected %h, got %h", e.xbyte, b);
                    mismatches++;
                end
                if (w !== e.wcode)
                begin
                    $error("wait_code: expected %0d, got %0d", e.wcode, w);
                    mismatches++;
                end
                if (l !== e.last_flag)
                begin
                    $error("last: expected %0d, got %0d", e.last_flag, l);
                    mismatches++;
                end
            end
        endfunction

        function bit closeout();
            if (owed.size() != 0)
            begin
                $error("%0d expander bytes never arrived", owed.size());
            end
            return (mismatches == 0) && (owed.size() == 0);
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write_en = 1'b0;
    logic [5:0] cfg_write_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] req_type = '0;
    logic [7:0] char_code = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] expander_byte;
    logic [2:0] wait_code;
    logic       last;

    display_scoreboard sb = new();

    bit          quiet = 1'b0;
    int unsigned gap_pct = 25;
    int unsigned holds_asked = 0;
    int unsigned holds_done = 0;
    logic [5:0]  mid_width;

    char_lcd_nibble_writer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .char_code      (char_code),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .expander_byte  (expander_byte),
        .wait_code      (wait_code),
        .last           (last)
    );

    always #1 clk = ~clk;

    // output side: random stalls, long hold-off on demand
    always
    begin
        if (holds_done < holds_asked)
        begin
            holds_done++;
            out_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clk);
        end
        else if (!quiet && $urandom_range(0, 3) == 0)
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        else
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    end

    // check every accepted output byte
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_byte(expander_byte, wait_code, last);
        end
    end

    // stall watchdog
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    // offer one request and wait until it is taken
    task automatic send_request(input logic [1:0] rq, input logic [7:0] ch);
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= rq;
        char_code <= ch;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(rq, ch);
    endtask

    // stop offering until every owed byte has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge clk);
    endtask

    // idle the block and change the line width
    task automatic write_line_width(input logic [5:0] w);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= w;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        sb.set_width(w);
    endtask

    function automatic logic [7:0] random_char();
        if ($urandom_range(0, 5) == 0)
        begin
            return CHAR_NEWLINE;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // mostly whole messages, some init, unused codes and stray characters
    task automatic send_random_until(input int unsigned goal);
        int unsigned pick;
        int unsigned len;
        while (sb.productive < goal)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 15)
            begin
                send_request(REQ_START, 8'($urandom));
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 40)
                                                   : $urandom_range(0, 24);
                repeat (len) send_request(REQ_CHAR, random_char());
            end
            else if (pick < 17)
            begin
                send_request(REQ_INIT, 8'($urandom));
            end
            else if (pick < 18)
            begin
                send_request(REQ_UNUSED, 8'($urandom));
            end
            else
            begin
                send_request(REQ_CHAR, random_char());
            end
        end
    endtask

    initial
    begin : stimulus
        int k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: init, extremes, newline swallow and pass-through, unused code, wrap
        send_request(REQ_INIT, 8'h00);
        send_request(REQ_START, 8'hFF);
        send_request(REQ_CHAR, 8'h00);
        send_request(REQ_CHAR, 8'hFF);
        send_request(REQ_CHAR, CHAR_NEWLINE);
        send_request(REQ_CHAR, CHAR_NEWLINE);
        send_request(REQ_UNUSED, 8'hFF);
        send_request(REQ_START, 8'h00);
        for (k = 0; k < 16; k++)
        begin
            send_request(REQ_CHAR, 8'h41 + 8'(k));
        end
        send_request(REQ_CHAR, CHAR_NEWLINE);

        // narrowest legal width
        write_line_width(6'd1);
        send_random_until(50);

        // widest legal width, with a long output hold-off
        write_line_width(6'd40);
        holds_asked++;
        send_random_until(80);

        // width zero moves before the first character
        write_line_width(6'd0);
        gap_pct = 5;
        send_random_until(95);
        drain_results();
        send_random_until(110);

        // largest register value never moves
        write_line_width(6'd63);
        gap_pct = 40;
        send_random_until(140);

        mid_width = 6'($urandom_range(2, 39));
        write_line_width(mid_width);
        gap_pct = 25;
        send_random_until(165);

        // width equal to the message limit, no idling
        write_line_width(6'(MSG_LIMIT));
        quiet = 1'b1;
        send_random_until(185);

        drain_results();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        $display("covered %0d requests (%0d with output), %0d expander bytes checked",
                 sb.accepted, sb.productive, sb.checked);
        $display("line widths 16, 1, 40, 0, 63, %0d and %0d, with long output hold-off",
                 mid_width, MSG_LIMIT);
        if (sb.closeout())
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
